>>> rtl/core/slfr_pkg.sv
// Package for the sync/length frame receiver: sizing constants, sync and
// trailer byte values, and the frame status codes. No dependencies.
package slfr_pkg;

  // Largest accepted total frame length (header and check bytes included).
  localparam int unsigned MAX_FRAME = 256;
  // Smallest legal length: sync pair, length pair and one check byte.
  localparam int unsigned MIN_FRAME = 5;

  // Position counter holds 0 .. MAX_FRAME-1.
  localparam int unsigned POS_W = $clog2(MAX_FRAME + 1);

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;

  localparam logic [BYTE_W-1:0] SYNC_FIRST   = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND  = 8'hAA;
  localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'h00;

  localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(MIN_FRAME);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_SYNC_REJ  = 3'd1,
    ST_GOOD      = 3'd2,
    ST_BAD_CHECK = 3'd3,
    ST_BAD_LEN   = 3'd4
  } frame_status_t;

endpackage

>>> rtl/core/sync_length_frame_receiver.sv
// Sync/length framed byte receiver: one module, byte in, annotated byte out.
// Depends on slfr_pkg for constants and the frame status type.
//
// Usage
//   in_* channel: one received byte per beat (in_valid/in_ready).
//   out_* channel: one result beat per input beat, carrying the byte, its
//     position in the frame, the frame status, a last flag and the captured
//     length field (out_valid/out_ready).
//   cfg_*: cfg_wr_en writes cfg_wr_data into check_mode (0 = two zero
//     trailer bytes, 1 = XOR checksum byte); write only while idle.
// Framing: hunt for 0x55 0xAA, then a big-endian 16-bit total length. The
//   last byte of a frame (position length-1) carries good/bad status. Bad
//   sync or a length outside MIN_FRAME..MAX_FRAME ends the attempt early.
// Timing: a result beat is valid in the cycle after its input beat is taken.
//   Throughput is one byte per cycle unless out_ready stalls; the frame state
//   and result register update in the same cycle an input beat is accepted.
// Stall: in_ready is high when the result register is empty or being
//   drained this cycle, so a stalled receiver holds exactly one result and
//   back-pressures the input.
// Reset: rst_n (synchronous, active low) empties the result register,
//   returns to hunting and clears check_mode.
module sync_length_frame_receiver
  import slfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   in_rx_byte,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [BYTE_W-1:0]   out_byte_out,
  output logic [7:0]          out_byte_position,
  output frame_status_t       out_frame_status,
  output logic                out_frame_last,
  output logic [LEN_W-1:0]    out_frame_length
);

  // Frame state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [LEN_W-1:0]  length_r, length_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [BYTE_W-1:0] prev_r;
  logic              check_mode_r;

  // Result register
  logic                out_valid_r;
  logic [BYTE_W-1:0]   res_byte_r;
  logic [7:0]          res_pos_r;
  frame_status_t       res_status_r, res_status_nxt;
  logic                res_last_r, res_last_nxt;
  logic [LEN_W-1:0]    res_len_r, res_len_nxt;

  logic              in_fire;
  logic [LEN_W:0]    pos_plus1;
  logic [LEN_W-1:0]  len_full;
  logic              end_of_frame;
  logic              check_good;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Length assembled from the captured high byte and the current low byte.
  assign len_full  = {length_r[LEN_W-1:BYTE_W], in_rx_byte};
  assign pos_plus1 = (LEN_W+1)'(pos_r) + (LEN_W+1)'(1);
  assign end_of_frame = (pos_plus1 >= {1'b0, length_r});

  always_comb begin
    if (check_mode_r) begin
      check_good = (xor_r == in_rx_byte);
    end else begin
      check_good = (in_rx_byte == TRAILER_BYTE) && (prev_r == TRAILER_BYTE);
    end
  end

  // Next frame state and result fields for the byte at the input.
  always_comb begin
    pos_nxt        = pos_r;
    length_nxt     = length_r;
    xor_nxt        = xor_r;
    res_status_nxt = ST_NONE;
    res_last_nxt   = 1'b0;
    res_len_nxt    = '0;
    if (pos_r == POS_W'(0)) begin
      // hunting
      if (in_rx_byte == SYNC_FIRST) begin
        xor_nxt    = in_rx_byte;
        length_nxt = '0;
        pos_nxt    = POS_W'(1);
      end
    end else if (pos_r == POS_W'(1)) begin
      if (in_rx_byte == SYNC_SECOND) begin
        xor_nxt = xor_r ^ in_rx_byte;
        pos_nxt = POS_W'(2);
      end else begin
        res_status_nxt = ST_SYNC_REJ;
        res_last_nxt   = 1'b1;
        pos_nxt        = '0;
      end
    end else if (pos_r == POS_W'(2)) begin
      length_nxt = {in_rx_byte, {BYTE_W{1'b0}}};
      xor_nxt    = xor_r ^ in_rx_byte;
      pos_nxt    = POS_W'(3);
    end else if (pos_r == POS_W'(3)) begin
      length_nxt  = len_full;
      res_len_nxt = len_full;
      if (len_full < MIN_LEN || len_full > MAX_LEN) begin
        res_status_nxt = ST_BAD_LEN;
        res_last_nxt   = 1'b1;
        pos_nxt        = '0;
      end else begin
        xor_nxt = xor_r ^ in_rx_byte;
        pos_nxt = POS_W'(4);
      end
    end else begin
      res_len_nxt = length_r;
      if (end_of_frame) begin
        res_status_nxt = check_good ? ST_GOOD : ST_BAD_CHECK;
        res_last_nxt   = 1'b1;
        pos_nxt        = '0;
      end else begin
        xor_nxt = xor_r ^ in_rx_byte;
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      length_r     <= '0;
      xor_r        <= '0;
      prev_r       <= '0;
      check_mode_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        check_mode_r <= cfg_wr_data;
      end
      if (in_fire) begin
        pos_r    <= pos_nxt;
        length_r <= length_nxt;
        xor_r    <= xor_nxt;
        prev_r   <= in_rx_byte;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_byte_r   <= in_rx_byte;
      res_pos_r    <= 8'(pos_r);
      res_status_r <= res_status_nxt;
      res_last_r   <= res_last_nxt;
      res_len_r    <= res_len_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte_out      = res_byte_r;
  assign out_byte_position = res_pos_r;
  assign out_frame_status  = res_status_r;
  assign out_frame_last    = res_last_r;
  assign out_frame_length  = res_len_r;

  // Checks

  // A byte other than the first sync byte leaves the hunt in place.
  a_hunt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && pos_r == '0 && in_rx_byte != SYNC_FIRST |=> pos_r == '0)
    else $error("left hunting without sync byte");

  // Inside the frame body the captured length is always a legal one.
  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r >= POS_W'(4) |-> length_r >= MIN_LEN && length_r <= MAX_LEN)
    else $error("frame body with illegal length");

  // A last flag always comes with a non-zero status, and only then.
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_last_r == (res_status_r != ST_NONE))
    else $error("last flag and status disagree");

  // The body position never reaches the captured length.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r >= POS_W'(4) |-> (LEN_W+1)'(pos_r) < {1'b0, length_r})
    else $error("position ran past frame length");

endmodule
